// ===== src/smc_pkg.sv =====
// ----------------------------------------------------------------------------
// smc_pkg
// Shared types and constants of the stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none

package smc_pkg;

  localparam int unsigned CodeDepth  = 1024;
  localparam int unsigned StackDepth = 64;
  localparam int unsigned CallDepth  = 16;

  localparam int unsigned CodeAw  = $clog2(CodeDepth);
  localparam int unsigned StackAw = $clog2(StackDepth);
  localparam int unsigned CallAw  = $clog2(CallDepth);

  // item actions
  localparam logic [1:0] ActLoad  = 2'd0;
  localparam logic [1:0] ActStart = 2'd1;
  localparam logic [1:0] ActStep  = 2'd2;

  // status codes
  localparam logic [2:0] StRun   = 3'd0;
  localparam logic [2:0] StHalt  = 3'd1;
  localparam logic [2:0] StBadOp = 3'd2;
  localparam logic [2:0] StDivZ  = 3'd3;
  localparam logic [2:0] StStack = 3'd4;

  // opcodes
  localparam logic [4:0] OpPush  = 5'd0;
  localparam logic [4:0] OpIAdd  = 5'd1;
  localparam logic [4:0] OpISub  = 5'd2;
  localparam logic [4:0] OpIMul  = 5'd3;
  localparam logic [4:0] OpIDiv  = 5'd4;
  localparam logic [4:0] OpIMod  = 5'd5;
  localparam logic [4:0] OpIEq   = 5'd6;
  localparam logic [4:0] OpINeq  = 5'd7;
  localparam logic [4:0] OpBAdd  = 5'd8;
  localparam logic [4:0] OpBSub  = 5'd9;
  localparam logic [4:0] OpBMul  = 5'd10;
  localparam logic [4:0] OpBDiv  = 5'd11;
  localparam logic [4:0] OpBEq   = 5'd12;
  localparam logic [4:0] OpBNeq  = 5'd13;
  localparam logic [4:0] OpIPr   = 5'd14;
  localparam logic [4:0] OpIPrLn = 5'd15;
  localparam logic [4:0] OpBPr   = 5'd16;
  localparam logic [4:0] OpBPrLn = 5'd17;
  localparam logic [4:0] OpCall  = 5'd18;
  localparam logic [4:0] OpRet   = 5'd19;
  localparam logic [4:0] OpJmp   = 5'd20;
  localparam logic [4:0] OpBrt   = 5'd21;
  localparam logic [4:0] OpBrf   = 5'd22;
  localparam logic [4:0] OpHalt  = 5'd23;

  typedef struct packed {
    logic [1:0]         action;
    logic [9:0]         address;
    logic [4:0]         word_opcode;
    logic signed [31:0] word_value;
    logic [3:0]         word_arg_count;
  } smc_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [9:0]         program_counter;
    logic               print_valid;
    logic               print_kind;
    logic               print_newline;
    logic signed [31:0] print_value;
  } smc_out_t;

  typedef struct packed {
    logic [4:0]  opcode;
    logic [31:0] value;
    logic [3:0]  arg_count;
  } code_word_t;

endpackage

`default_nettype wire

// ===== src/stack_machine_core.sv =====
// ----------------------------------------------------------------------------
// stack_machine_core
// Stack machine: code, data stack and return stack in synchronous RAMs,
// one instruction per step beat through a small sequencer.
// ----------------------------------------------------------------------------
// a load or start gets a registered result beat; a step passes through opcode
//   read, operand read, execute and write back, and the result beat
// integer divide and modulo add a pass through the bit-serial divider
// busy covers a step from acceptance until its result beat; loads and starts
//   never raise it, so they can follow back to back
// reset: pc, stack pointer and call depth zero, status halted; memories undefined
`default_nettype none

module stack_machine_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start,
  output logic                     busy,
  input  wire smc_pkg::smc_in_t    in_i,
  output logic                     done_o,
  output smc_pkg::smc_out_t        out_o
);
  import smc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FETCH, S_READ, S_EXEC, S_DIV, S_DONE
  } state_e;

  localparam int unsigned SpW = StackAw + 1;
  localparam int unsigned CdW = CallAw + 1;

  // memories
  code_word_t        code_mem [CodeDepth];
  logic [31:0]       data_mem [StackDepth];
  logic [CodeAw-1:0] ret_mem  [CallDepth];

  state_e             state_q;
  logic [CodeAw-1:0]  pc_q;
  logic [SpW-1:0]     sp_q;
  logic [CdW-1:0]     cd_q;
  logic [2:0]         st_q;
  logic               busy_q, done_q;
  smc_out_t           out_q;

  // read ports
  logic [CodeAw-1:0]  code_ra;
  code_word_t         code_rd_q;
  logic [StackAw-1:0] ds_ra_a, ds_ra_b;
  logic [31:0]        ds_rd_a_q, ds_rd_b_q;
  logic [CodeAw-1:0]  ret_rd_q;
  // latched instruction
  logic [4:0]         op_q;
  code_word_t         opnd_q;

  logic [CodeAw-1:0]  nx, nx2;
  logic [SpW-1:0]     sp_m1, sp_m2;

  assign nx    = pc_q + CodeAw'(1);
  assign nx2   = pc_q + CodeAw'(2);
  assign sp_m1 = sp_q - SpW'(1);
  assign sp_m2 = sp_q - SpW'(2);
  assign ds_ra_a = sp_m1[StackAw-1:0];
  assign ds_ra_b = sp_m2[StackAw-1:0];

  // code address: pc + 1 for the operand word in fetch, pc for the opcode otherwise
  always_comb begin
    code_ra = (state_q == S_FETCH) ? nx : pc_q;
  end

  // code memory: load writes, one read port
  always_ff @(posedge clk_i) begin
    if (start && !busy_q && in_i.action == ActLoad) begin
      code_mem[in_i.address[CodeAw-1:0]] <= '{in_i.word_opcode, in_i.word_value,
                                              in_i.word_arg_count};
    end
    code_rd_q <= code_mem[code_ra];
  end

  // divider signals
  logic [31:0] dv_rem_q, dv_quo_q, dv_den_q;
  logic [5:0]  dv_cnt_q;
  logic        dv_nq_q, dv_nr_q;
  logic [32:0] dv_trial;
  logic [31:0] dv_rem_sh;
  assign dv_rem_sh = {dv_rem_q[30:0], dv_quo_q[31]};
  assign dv_trial  = {dv_rem_q, dv_quo_q[31]} - {1'b0, dv_den_q};

  // execute decode
  logic [31:0] a, b, r;
  logic        ab, bb, mem_wr, ret_wr;
  logic [StackAw-1:0] ds_wa;
  logic [31:0] ds_wd;
  logic [2:0]  st_n;
  logic [CodeAw-1:0] pc_n;
  logic [SpW-1:0] sp_n;
  logic [CdW-1:0] cd_n;
  logic        pv, pk, pn, go_div;
  logic [31:0] pval;

  assign a  = ds_rd_b_q;
  assign b  = ds_rd_a_q;
  assign ab = (a != '0);
  assign bb = (b != '0);

  always_comb begin
    st_n = st_q; pc_n = pc_q; sp_n = sp_q; cd_n = cd_q;
    mem_wr = 1'b0; ret_wr = 1'b0; ds_wa = ds_ra_b; ds_wd = '0;
    pv = 1'b0; pk = 1'b0; pn = 1'b0; pval = '0; go_div = 1'b0; r = '0;
    if (op_q >= OpIAdd && op_q <= OpBNeq) begin
      if (sp_q < SpW'(2) || sp_q > SpW'(StackDepth)) begin
        st_n = StStack;
      end else begin
        case (op_q)
          OpIAdd: r = a + b;
          OpISub: r = a - b;
          OpIMul: r = a * b;
          OpIEq:  r = {31'd0, a == b};
          OpINeq: r = {31'd0, a != b};
          OpBAdd: r = {30'd0, {1'b0, ab} + {1'b0, bb}};
          OpBSub: r = {31'd0, ab} - {31'd0, bb};
          OpBMul: r = {31'd0, ab && bb};
          OpBDiv: r = {31'd0, ab};
          OpBEq:  r = {31'd0, ab == bb};
          default: r = {31'd0, ab != bb};
        endcase
        if ((op_q == OpIDiv || op_q == OpIMod || op_q == OpBDiv) && !bb) begin
          st_n = StDivZ;
        end else if (op_q == OpIDiv || op_q == OpIMod) begin
          go_div = 1'b1;
        end else begin
          mem_wr = 1'b1; ds_wd = r; sp_n = sp_m1; pc_n = nx;
        end
      end
    end else begin
      case (op_q)
        OpPush: begin
          if (sp_q >= SpW'(StackDepth)) st_n = StStack;
          else begin
            mem_wr = 1'b1; ds_wa = sp_q[StackAw-1:0]; ds_wd = opnd_q.value;
            sp_n = sp_q + SpW'(1); pc_n = nx2;
          end
        end
        OpIPr, OpIPrLn, OpBPr, OpBPrLn: begin
          if (sp_q == '0 || sp_q > SpW'(StackDepth)) st_n = StStack;
          else begin
            sp_n = sp_m1; pc_n = nx; pv = 1'b1;
            pk = (op_q == OpBPr || op_q == OpBPrLn);
            pn = (op_q == OpIPrLn || op_q == OpBPrLn);
            pval = pk ? {31'd0, bb} : b;
          end
        end
        OpCall: begin
          if (cd_q >= CdW'(CallDepth) || sp_q < SpW'(opnd_q.arg_count)) st_n = StStack;
          else begin
            ret_wr = 1'b1; cd_n = cd_q + CdW'(1);
            sp_n = sp_q - SpW'(opnd_q.arg_count);
            pc_n = opnd_q.value[CodeAw-1:0];
          end
        end
        OpRet: begin
          if (cd_q == '0 || cd_q > CdW'(CallDepth)) st_n = StStack;
          else begin
            cd_n = cd_q - CdW'(1); pc_n = ret_rd_q + CodeAw'(1);
          end
        end
        OpJmp: pc_n = opnd_q.value[CodeAw-1:0];
        OpBrt, OpBrf: begin
          if (sp_q == '0 || sp_q > SpW'(StackDepth)) st_n = StStack;
          else begin
            sp_n = sp_m1;
            pc_n = ((op_q == OpBrt) == bb) ? opnd_q.value[CodeAw-1:0] : nx2;
          end
        end
        OpHalt: begin st_n = StHalt; pc_n = nx; end
        default: st_n = StBadOp;
      endcase
    end
  end

  // divide result with sign fixups
  logic [31:0] dv_q_s, dv_r_s;
  assign dv_q_s = dv_nq_q ? -dv_quo_q : dv_quo_q;
  assign dv_r_s = dv_nr_q ? -dv_rem_q : dv_rem_q;

  // data and return stacks
  logic div_wr;
  assign div_wr = (state_q == S_DIV) && (dv_cnt_q == '0);
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && mem_wr) data_mem[ds_wa] <= ds_wd;
    else if (div_wr) data_mem[ds_ra_b] <= (op_q == OpIMod) ? dv_r_s : dv_q_s;
    ds_rd_a_q <= data_mem[ds_ra_a];
    ds_rd_b_q <= data_mem[ds_ra_b];
    if (state_q == S_EXEC && ret_wr) ret_mem[cd_q[CallAw-1:0]] <= nx;
    ret_rd_q <= ret_mem[cd_q[CallAw-1:0] - CallAw'(1)];
  end

  // divider datapath, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC && go_div) begin
      dv_rem_q <= '0;
      dv_quo_q <= a[31] ? -a : a;
      dv_den_q <= b[31] ? -b : b;
      dv_nq_q  <= a[31] ^ b[31];
      dv_nr_q  <= a[31];
    end else if (state_q == S_DIV && dv_cnt_q != '0) begin
      if (!dv_trial[32]) begin
        dv_rem_q <= dv_trial[31:0];
        dv_quo_q <= {dv_quo_q[30:0], 1'b1};
      end else begin
        dv_rem_q <= dv_rem_sh;
        dv_quo_q <= {dv_quo_q[30:0], 1'b0};
      end
    end
  end

  // sequencer and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; pc_q <= '0; sp_q <= '0; cd_q <= '0; st_q <= StHalt;
      busy_q <= 1'b0; done_q <= 1'b0; dv_cnt_q <= '0; op_q <= '0;
      opnd_q <= '0; out_q <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (in_i.action == ActStep && st_q == StRun) begin
              state_q <= S_FETCH; busy_q <= 1'b1;
            end else begin
              if (in_i.action == ActStart) begin
                pc_q <= in_i.address[CodeAw-1:0]; sp_q <= '0; cd_q <= '0;
                st_q <= StRun;
                out_q <= '{StRun, in_i.address, 1'b0, 1'b0, 1'b0, 32'sd0};
              end else begin
                out_q <= '{st_q, 10'(pc_q), 1'b0, 1'b0, 1'b0, 32'sd0};
              end
              done_q <= 1'b1;
            end
          end
        end
        // opcode word is on the read port here, operand word in the read state that follows
        S_FETCH: begin
          op_q <= code_rd_q.opcode; state_q <= S_READ;
        end
        S_READ: begin
          opnd_q <= code_rd_q; state_q <= S_EXEC;
        end
        S_EXEC: begin
          if (go_div) begin
            state_q <= S_DIV; dv_cnt_q <= 6'd32;
          end else begin
            pc_q <= pc_n; sp_q <= sp_n; cd_q <= cd_n; st_q <= st_n;
            out_q <= '{st_n, 10'(pc_n), pv, pk, pn, pval};
            state_q <= S_DONE;
          end
        end
        S_DIV: begin
          if (dv_cnt_q == '0) begin
            sp_q <= sp_m1; pc_q <= nx;
            out_q <= '{st_q, 10'(nx), 1'b0, 1'b0, 1'b0, 32'sd0};
            state_q <= S_DONE;
          end else dv_cnt_q <= dv_cnt_q - 6'd1;
        end
        S_DONE: begin
          done_q <= 1'b1; busy_q <= 1'b0; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = busy_q;
  assign done_o = done_q;
  assign out_o  = out_q;

endmodule

`default_nettype wire

// ===== src/smc_checker.sv =====
// ----------------------------------------------------------------------------
// smc_core_checker
// Port-level checks of the stack machine core.
// ----------------------------------------------------------------------------
`default_nettype none

module smc_core_checker (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              start,
  input wire logic              busy,
  input wire smc_pkg::smc_in_t  in_i,
  input wire logic              done_o,
  input wire smc_pkg::smc_out_t out_o
);
  import smc_pkg::*;

  // a result beat never shows while a step is in flight
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(busy && done_o)) else $error("result beat while busy");

  // an accepted beat that is not a step reports on the next cycle
  a_quick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && in_i.action != ActStep) |=> done_o) else $error("missing result");

  // every accepted beat either reports or raises busy on the next cycle
  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || done_o)) else $error("beat dropped");

  // a print only appears while the machine keeps running
  a_print: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.print_valid) |-> (out_o.status == StRun))
    else $error("print on fault");

  // busy drops only with a result beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> done_o) else $error("busy dropped without result");

endmodule

bind stack_machine_core smc_core_checker u_smc_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
  .done_o(done_o), .out_o(out_o)
);

`default_nettype wire
